>>> hdl/blre_pkg.sv
package blre_pkg;

  localparam int ENTRIES = 32;
  localparam int SLOT_W = 5;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int BYTES_W = 40;
  localparam int FRAME_W = 32;
  localparam int TOTAL_W = 45;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TOUCH = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_EVICT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_EVICTED  = 2'd2,
    ST_WITHIN   = 2'd3
  } status_t;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_MIN_AGE = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot;
    logic [BYTES_W-1:0] size_bytes;
    logic               load_ok;
    logic               pin;
    logic [FRAME_W-1:0] frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_out;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EXEC,
    S_SCAN,
    S_DROP,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic drop;
    logic set_final;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_evict;
    logic over_budget;
    logic scan_done;
    logic found;
  } sts_t;

endpackage

>>> hdl/blre_ctrl.sv
module blre_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  blre_pkg::sts_t  sts,
  output blre_pkg::cmd_t  cmd
);
  import blre_pkg::*;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        if (sts.is_evict && sts.over_budget) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        last_nxt  = 1'b1;
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.drop = 1'b1;
            last_nxt = 1'b0;
          end else begin
            cmd.set_final = 1'b1;
            last_nxt      = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else if (sts.over_budget) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.set_final = 1'b1;
            last_nxt      = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> hdl/blre_dp.sv
module blre_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  blre_pkg::in_item_t  in_item,
  input  logic [39:0]         cfg_budget,
  input  logic [31:0]         cfg_min_age,
  input  blre_pkg::cmd_t      cmd,
  output blre_pkg::sts_t      sts,
  output blre_pkg::out_item_t out_item
);
  import blre_pkg::*;

  logic [ENTRIES-1:0] in_use_r, resident_r, pinned_r;
  logic [BYTES_W-1:0] bytes_mem [ENTRIES];
  logic [FRAME_W-1:0] used_mem [ENTRIES];
  logic [TOTAL_W-1:0] total_r;
  logic               ready_r;
  in_item_t           req_r;
  logic [BYTES_W-1:0] rd_bytes_r;
  logic [1:0]         status_r;
  logic [SLOT_W-1:0]  slot_out_r;

  // scan state
  logic [IDX_W:0]     scan_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_r;
  logic [FRAME_W-1:0] best_used_r;
  logic [BYTES_W-1:0] best_bytes_r;

  // slot read by the scan, registered from the slot that scan_r addresses
  logic [FRAME_W-1:0] rd_used_r;
  logic [BYTES_W-1:0] rd_sbytes_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_elig_r;
  logic               rd_vld_r;

  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   sidx;
  logic               cand;
  logic [FRAME_W:0]   age_sum;

  assign in_range = ({3'b0, req_r.slot} < (SLOT_W + 3)'(ENTRIES));
  assign idx      = req_r.slot[IDX_W-1:0];
  assign sidx     = scan_r[IDX_W-1:0];
  assign age_sum  = {1'b0, rd_used_r} + {1'b0, cfg_min_age};
  assign cand     = rd_vld_r && rd_elig_r && (age_sum <= {1'b0, req_r.frame});

  assign sts.is_evict    = (req_r.kind == KIND_EVICT);
  assign sts.over_budget = (total_r > {5'b0, cfg_budget});
  assign sts.scan_done   = scan_r[IDX_W] && !rd_vld_r;
  assign sts.found       = found_r;

  assign out_item.status      = status_r;
  assign out_item.slot_out    = slot_out_r;
  assign out_item.total_bytes = total_r;
  assign out_item.last        = 1'b0;

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_item;
    rd_bytes_r  <= bytes_mem[idx];
    rd_used_r   <= used_mem[sidx];
    rd_sbytes_r <= bytes_mem[sidx];
    rd_idx_r    <= sidx;
    rd_elig_r   <= in_use_r[sidx] && resident_r[sidx] && !pinned_r[sidx];
    if (cand && (!found_r || rd_used_r < best_used_r)) begin
      best_r       <= rd_idx_r;
      best_used_r  <= rd_used_r;
      best_bytes_r <= rd_sbytes_r;
    end
    if (cmd.scan_start) scan_r <= '0;
    else if (cmd.scan_step && !scan_r[IDX_W]) scan_r <= scan_r + 1'b1;
    if (cmd.exec) begin
      if (!in_range) begin
        status_r <= ST_NOT_USED;
      end else begin
        case (kind_t'(req_r.kind))
          KIND_LOAD: begin
            status_r <= ST_OK;
            used_mem[idx] <= '0;
            bytes_mem[idx] <= req_r.load_ok ? req_r.size_bytes : '0;
          end
          KIND_TOUCH: begin
            status_r <= in_use_r[idx] ? ST_OK : ST_NOT_USED;
            if (in_use_r[idx]) begin
              used_mem[idx] <= req_r.frame;
              if (!resident_r[idx] && ready_r && req_r.load_ok)
                bytes_mem[idx] <= req_r.size_bytes;
            end
          end
          KIND_CLEAR: status_r <= in_use_r[idx] ? ST_OK : ST_NOT_USED;
          default:    status_r <= ST_WITHIN;
        endcase
      end
      slot_out_r <= (req_r.kind == KIND_EVICT) ? '0 : req_r.slot;
    end
    if (cmd.drop) begin
      status_r   <= ST_EVICTED;
      slot_out_r <= SLOT_W'(best_r);
      bytes_mem[best_r] <= '0;
    end
    if (cmd.set_final) begin
      status_r   <= sts.over_budget ? ST_OK : ST_WITHIN;
      slot_out_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= '0;
      resident_r <= '0;
      pinned_r   <= '0;
      total_r    <= '0;
      ready_r    <= 1'b0;
      found_r    <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step && !scan_r[IDX_W];
      if (cmd.scan_start) found_r <= 1'b0;
      else if (cand) found_r <= 1'b1;
      if (cmd.exec && in_range) begin
        case (kind_t'(req_r.kind))
          KIND_LOAD: begin
            in_use_r[idx]   <= 1'b1;
            pinned_r[idx]   <= req_r.pin;
            resident_r[idx] <= req_r.load_ok;
            ready_r         <= 1'b1;
            total_r <= total_r
                       - ((in_use_r[idx] && resident_r[idx]) ? {5'b0, rd_bytes_r} : '0)
                       + (req_r.load_ok ? {5'b0, req_r.size_bytes} : '0);
          end
          KIND_TOUCH: begin
            if (in_use_r[idx] && !resident_r[idx] && ready_r && req_r.load_ok) begin
              resident_r[idx] <= 1'b1;
              total_r <= total_r + {5'b0, req_r.size_bytes};
            end
          end
          KIND_CLEAR: begin
            if (in_use_r[idx]) begin
              if (resident_r[idx]) total_r <= total_r - {5'b0, rd_bytes_r};
              in_use_r[idx]   <= 1'b0;
              resident_r[idx] <= 1'b0;
              pinned_r[idx]   <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.drop) begin
        resident_r[best_r] <= 1'b0;
        total_r <= total_r - {5'b0, best_bytes_r};
      end
    end
  end
endmodule

>>> hdl/budget_lru_residency_evictor_unit.sv
// Residency table of 32 slots with LRU eviction under a byte budget. The input
// is stalled from acceptance until the last result of the transaction is taken.
// Load, touch, clear and an evict within budget go through accept, read,
// execute and result and give one result. An evict over budget reads, then
// scans the table one slot a cycle through a registered read and drops the
// oldest eligible entry with a result for each eviction, scanning again while
// still over budget, then gives the final result; a scan that finds nothing
// gives the final result. Output stalls hold each result. Configuration is to
// be written only while idle; the user must keep to this, as the block itself
// does not enforce it. No clearing pass after reset.
module budget_lru_residency_evictor_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  blre_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output blre_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [39:0]         cfg_wdata
);
  import blre_pkg::*;

  logic [39:0] budget_r;
  logic [31:0] min_age_r;
  cmd_t        cmd;
  sts_t        sts;
  out_item_t   dp_out;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r  <= '1;
      min_age_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BUDGET) budget_r <= cfg_wdata;
      else if (cfg_index == CFG_MIN_AGE) min_age_r <= cfg_wdata[31:0];
    end
  end

  // last flag: set on results that end the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) last_r <= 1'b0;
    else if (cmd.exec || cmd.set_final) last_r <= 1'b1;
    else if (cmd.drop) last_r <= 1'b0;
  end

  blre_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  blre_dp u_dp (
    .clk, .rst_n, .in_item(in_data), .cfg_budget(budget_r),
    .cfg_min_age(min_age_r), .cmd, .sts, .out_item(dp_out)
  );

  always_comb begin
    out_data      = dp_out;
    out_data.last = last_r;
  end
endmodule
